FILE: rtl/isolated_pixel_class_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the isolated pixel class filter checks.
// ----------------------------------------------------------------------------
`ifndef ISOLATED_PIXEL_CLASS_FILTER_CORE_ASSERT_SVH
`define ISOLATED_PIXEL_CLASS_FILTER_CORE_ASSERT_SVH

// same-cycle implication, switched off while reset is held
`define IPCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, switched off while reset is held
`define IPCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// next-cycle implication that also holds through reset
`define IPCF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

FILE: rtl/ipcf_pkg.sv
// ----------------------------------------------------------------------------
// ipcf_pkg
// Constants, types and register codes of the isolated pixel class filter.
// ----------------------------------------------------------------------------
package ipcf_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int NEIGHBOURS = 8;

    // field and counter widths
    localparam int PIX_W = 8;
    localparam int DIM_W = 11;
    localparam int WID_W = $clog2(MAX_WIDTH + 2);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // history store: deepest tap is two rows plus two pixels back
    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int PTR_W      = $clog2(HIST_DEPTH + 1);
    localparam int BANK_SEL_W = 2;
    localparam int BANKS      = 1 << BANK_SEL_W;
    localparam int ROW_ADDR_W = PTR_W - BANK_SEL_W;
    localparam int BANK_DEPTH = 1 << ROW_ADDR_W;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(1024);

    typedef logic [PIX_W-1:0]      pixel_t;
    typedef logic [DIM_W-1:0]      dim_t;
    typedef logic [BANK_SEL_W-1:0] bank_sel_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = REG_IDX_W'(0),
        REG_FRAME_HEIGHT = REG_IDX_W'(1)
    } reg_idx_t;

    // position flags of the item being taken
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } pos_t;

    // registered 3x3 window
    typedef struct packed {
        pos_t                        pos;
        pixel_t                      centre;
        pixel_t                      newest;
        pixel_t [NEIGHBOURS-1:0]     nbr;
    } win_t;

    // one result item
    typedef struct packed {
        pixel_t class_out;
        logic   replaced;
        logic   last;
    } res_t;

endpackage

FILE: rtl/ipcf_bank_ram.sv
// ----------------------------------------------------------------------------
// ipcf_bank_ram
// One bank of the pixel history: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ipcf_bank_ram (
    input  logic                                clk,
    input  logic                                we,
    input  logic [ipcf_pkg::ROW_ADDR_W-1:0]     waddr,
    input  ipcf_pkg::pixel_t                    wdata,
    input  logic                                re,
    input  logic [ipcf_pkg::ROW_ADDR_W-1:0]     raddr_a,
    input  logic [ipcf_pkg::ROW_ADDR_W-1:0]     raddr_b,
    output ipcf_pkg::pixel_t                    rdata_a,
    output ipcf_pkg::pixel_t                    rdata_b
);

    ipcf_pkg::pixel_t mem_reg [ipcf_pkg::BANK_DEPTH];
    ipcf_pkg::pixel_t rd_a_reg;
    ipcf_pkg::pixel_t rd_b_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read ports, data registered
    always_ff @(posedge clk) begin
        if (re) begin
            rd_a_reg <= mem_reg[raddr_a];
            rd_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

FILE: rtl/ipcf_scan.sv
// ----------------------------------------------------------------------------
// ipcf_scan
// Fill count and output position tracking; flags the item being taken.
// ----------------------------------------------------------------------------
module ipcf_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [ipcf_pkg::WID_W-1:0]      width,
    input  logic [ipcf_pkg::HGT_W-1:0]      height,
    output ipcf_pkg::pos_t                  pos
);

    logic [ipcf_pkg::WID_W-1:0] fill_reg, fill_next;
    logic [ipcf_pkg::COL_W-1:0] col_reg, col_next;
    logic [ipcf_pkg::ROW_W-1:0] row_reg, row_next;

    logic [ipcf_pkg::WID_W-1:0] width_p1;
    logic [ipcf_pkg::WID_W-1:0] col_p1;
    logic [ipcf_pkg::HGT_W-1:0] row_p1;
    logic                       col_end;
    logic                       row_end;

    // position flags
    always_comb begin
        width_p1     = width + ipcf_pkg::WID_W'(1);
        col_p1       = ipcf_pkg::WID_W'(col_reg) + ipcf_pkg::WID_W'(1);
        row_p1       = ipcf_pkg::HGT_W'(row_reg) + ipcf_pkg::HGT_W'(1);
        col_end      = col_p1 >= width;
        row_end      = row_p1 >= height;
        pos.emit     = fill_reg >= width_p1;
        pos.interior = (col_reg != '0) && (col_p1 < width)
                       && (row_reg != '0) && (row_p1 < height);
        pos.last     = col_end && row_end;
    end

    // counter update on each item
    always_comb begin
        fill_next = fill_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            if (pos.emit) begin
                if (pos.last) begin
                    fill_next = '0;
                    col_next  = '0;
                    row_next  = '0;
                end else if (col_end) begin
                    col_next = '0;
                    row_next = row_reg + ipcf_pkg::ROW_W'(1);
                end else begin
                    col_next = col_reg + ipcf_pkg::COL_W'(1);
                end
            end else begin
                fill_next = fill_reg + ipcf_pkg::WID_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            fill_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

FILE: rtl/ipcf_window.sv
// ----------------------------------------------------------------------------
// ipcf_window
// Pixel history in four interleaved banks and the registered 3x3 window.
// ----------------------------------------------------------------------------
module ipcf_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  ipcf_pkg::pixel_t                cur,
    input  logic [ipcf_pkg::WID_W-1:0]      width,
    input  ipcf_pkg::pos_t                  pos_in,
    output ipcf_pkg::win_t                  win
);

    logic [ipcf_pkg::PTR_W-1:0] wptr_reg;
    logic [ipcf_pkg::PTR_W-1:0] base_a;
    logic [ipcf_pkg::PTR_W-1:0] base_b;

    ipcf_pkg::pixel_t h1_reg;
    ipcf_pkg::pixel_t h2_reg;

    ipcf_pkg::pixel_t    cur_reg;
    ipcf_pkg::pixel_t    t1_reg;
    ipcf_pkg::pixel_t    t2_reg;
    ipcf_pkg::bank_sel_t sel_a_reg;
    ipcf_pkg::bank_sel_t sel_b_reg;
    ipcf_pkg::pos_t      pos_reg;

    ipcf_pkg::pixel_t [ipcf_pkg::BANKS-1:0] rd_a;
    ipcf_pkg::pixel_t [ipcf_pkg::BANKS-1:0] rd_b;

    // one row back and two rows back from the newest item
    assign base_a = wptr_reg - ipcf_pkg::PTR_W'(width);
    assign base_b = wptr_reg - (ipcf_pkg::PTR_W'(width) << 1);

    // banks: three consecutive addresses always fall in distinct banks
    for (genvar b = 0; b < ipcf_pkg::BANKS; b++) begin : g_bank
        ipcf_pkg::bank_sel_t        off_a;
        ipcf_pkg::bank_sel_t        off_b;
        logic [ipcf_pkg::PTR_W-1:0] addr_a;
        logic [ipcf_pkg::PTR_W-1:0] addr_b;
        logic                       we;

        assign off_a  = base_a[ipcf_pkg::BANK_SEL_W-1:0] - ipcf_pkg::bank_sel_t'(b);
        assign off_b  = base_b[ipcf_pkg::BANK_SEL_W-1:0] - ipcf_pkg::bank_sel_t'(b);
        assign addr_a = base_a - ipcf_pkg::PTR_W'(off_a);
        assign addr_b = base_b - ipcf_pkg::PTR_W'(off_b);
        assign we     = accept
                        && (wptr_reg[ipcf_pkg::BANK_SEL_W-1:0] == ipcf_pkg::bank_sel_t'(b));

        ipcf_bank_ram u_ram (
            .clk     (clk),
            .we      (we),
            .waddr   (wptr_reg[ipcf_pkg::PTR_W-1:ipcf_pkg::BANK_SEL_W]),
            .wdata   (cur),
            .re      (accept),
            .raddr_a (addr_a[ipcf_pkg::PTR_W-1:ipcf_pkg::BANK_SEL_W]),
            .raddr_b (addr_b[ipcf_pkg::PTR_W-1:ipcf_pkg::BANK_SEL_W]),
            .rdata_a (rd_a[b]),
            .rdata_b (rd_b[b])
        );
    end

    // write pointer
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wptr_reg <= '0;
        end else if (accept) begin
            wptr_reg <= wptr_reg + ipcf_pkg::PTR_W'(1);
        end
    end

    // short history and window stage registers
    always_ff @(posedge clk) begin
        if (accept) begin
            h1_reg    <= cur;
            h2_reg    <= h1_reg;
            cur_reg   <= cur;
            t1_reg    <= h1_reg;
            t2_reg    <= h2_reg;
            sel_a_reg <= base_a[ipcf_pkg::BANK_SEL_W-1:0];
            sel_b_reg <= base_b[ipcf_pkg::BANK_SEL_W-1:0];
            pos_reg   <= pos_in;
        end
    end

    // gather the window from the bank read data
    always_comb begin
        win.pos    = pos_reg;
        win.newest = cur_reg;
        win.centre = rd_a[sel_a_reg - ipcf_pkg::bank_sel_t'(1)];
        win.nbr[0] = cur_reg;
        win.nbr[1] = t1_reg;
        win.nbr[2] = t2_reg;
        win.nbr[3] = rd_a[sel_a_reg];
        win.nbr[4] = rd_a[sel_a_reg - ipcf_pkg::bank_sel_t'(2)];
        win.nbr[5] = rd_b[sel_b_reg];
        win.nbr[6] = rd_b[sel_b_reg - ipcf_pkg::bank_sel_t'(1)];
        win.nbr[7] = rd_b[sel_b_reg - ipcf_pkg::bank_sel_t'(2)];
    end

endmodule

FILE: rtl/ipcf_decide.sv
// ----------------------------------------------------------------------------
// ipcf_decide
// Isolation test on the window and the result register.
// ----------------------------------------------------------------------------
module ipcf_decide (
    input  logic               clk,
    input  logic               load,
    input  ipcf_pkg::win_t     win,
    output ipcf_pkg::res_t     res
);

    ipcf_pkg::res_t                    res_reg, res_next;
    logic [ipcf_pkg::NEIGHBOURS-1:0]   differ;

    // replace an interior pixel that matches none of its neighbours
    always_comb begin
        for (int i = 0; i < ipcf_pkg::NEIGHBOURS; i++) begin
            differ[i] = win.nbr[i] != win.centre;
        end
        res_next.replaced  = win.pos.interior && (&differ);
        res_next.class_out = res_next.replaced ? win.newest : win.centre;
        res_next.last      = win.pos.last;
    end

    always_ff @(posedge clk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/isolated_pixel_class_filter_core.sv
// ----------------------------------------------------------------------------
// isolated_pixel_class_filter_core
// 3x3 isolated-pixel removal on a raster stream of class labels.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per clock once the window is
// full; the only limit on rate is the sink's ready. The item that completes a
// result passes first through the history read (four interleaved 8-bit banks,
// two registered read ports each, so the six row taps come out together) and
// then the neighbour compare into the output register. The first frame_width+1
// items of a frame give no result; after the frame send frame_width+1 flush
// items (s_kind high) to drain it. The history needs no clearing after reset.
// Width and height are clamped to 1..1024. They are to be written only while
// the block holds no pending result; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module isolated_pixel_class_filter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  ipcf_pkg::pixel_t                    s_class_in,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output ipcf_pkg::pixel_t                    m_class_out,
    output logic                                m_was_replaced,
    output logic                                m_last_of_frame,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipcf_pkg::PADDR_W-1:0]        paddr,
    input  logic [ipcf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ipcf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    ipcf_pkg::dim_t     width_reg;
    ipcf_pkg::dim_t     height_reg;
    ipcf_pkg::reg_idx_t reg_idx;
    logic               cfg_write;

    logic [ipcf_pkg::WID_W-1:0] width_eff;
    logic [ipcf_pkg::HGT_W-1:0] height_eff;

    logic               accept;
    ipcf_pkg::pixel_t   cur;
    ipcf_pkg::pos_t     pos;
    ipcf_pkg::win_t     win;
    ipcf_pkg::res_t     res;

    logic st1_valid_reg, st1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic st1_adv;
    logic out_load;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = ipcf_pkg::reg_idx_t'(paddr[ipcf_pkg::PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ipcf_pkg::FRAME_WIDTH_RESET;
            height_reg <= ipcf_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                ipcf_pkg::REG_FRAME_WIDTH: begin
                    width_reg <= pwdata[ipcf_pkg::DIM_W-1:0];
                end
                ipcf_pkg::REG_FRAME_HEIGHT: begin
                    height_reg <= pwdata[ipcf_pkg::DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ipcf_pkg::REG_FRAME_WIDTH:  prdata = ipcf_pkg::APB_DATA_W'(width_reg);
            ipcf_pkg::REG_FRAME_HEIGHT: prdata = ipcf_pkg::APB_DATA_W'(height_reg);
            default:                    prdata = '0;
        endcase
    end

    // clamp frame size to the supported range
    always_comb begin
        if (width_reg == '0) begin
            width_eff = ipcf_pkg::WID_W'(1);
        end else if (32'(width_reg) > 32'(ipcf_pkg::MAX_WIDTH)) begin
            width_eff = ipcf_pkg::WID_W'(ipcf_pkg::MAX_WIDTH);
        end else begin
            width_eff = ipcf_pkg::WID_W'(width_reg);
        end
        if (height_reg == '0) begin
            height_eff = ipcf_pkg::HGT_W'(1);
        end else if (32'(height_reg) > 32'(ipcf_pkg::MAX_HEIGHT)) begin
            height_eff = ipcf_pkg::HGT_W'(ipcf_pkg::MAX_HEIGHT);
        end else begin
            height_eff = ipcf_pkg::HGT_W'(height_reg);
        end
    end

    // pipeline flow: window stage then result register
    assign st1_adv  = !win.pos.emit || !out_valid_reg || m_ready;
    assign s_ready  = !st1_valid_reg || st1_adv;
    assign accept   = s_valid && s_ready;
    assign out_load = st1_valid_reg && win.pos.emit && st1_adv;
    assign cur      = s_kind ? '0 : s_class_in;

    always_comb begin
        st1_valid_next = s_ready ? s_valid : st1_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    ipcf_scan u_scan (
        .clk    (aclk),
        .rst_n  (aresetn),
        .accept (accept),
        .width  (width_eff),
        .height (height_eff),
        .pos    (pos)
    );

    ipcf_window u_window (
        .clk    (aclk),
        .rst_n  (aresetn),
        .accept (accept),
        .cur    (cur),
        .width  (width_eff),
        .pos_in (pos),
        .win    (win)
    );

    ipcf_decide u_decide (
        .clk  (aclk),
        .load (out_load),
        .win  (win),
        .res  (res)
    );

    // result item
    assign m_valid         = out_valid_reg;
    assign m_class_out     = res.class_out;
    assign m_was_replaced  = res.replaced;
    assign m_last_of_frame = res.last;

endmodule

FILE: rtl/ipcf_checker.sv
// ----------------------------------------------------------------------------
// ipcf_checker
// Port-level checks of the isolated pixel class filter, bound to the top.
// ----------------------------------------------------------------------------
`include "isolated_pixel_class_filter_core_assert.svh"

module ipcf_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input ipcf_pkg::pixel_t                     m_class_out,
    input logic                                 m_was_replaced,
    input logic                                 m_last_of_frame
);

    // a stalled result item holds
    `IPCF_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_class_out) && $stable(m_was_replaced) && $stable(m_last_of_frame))

    // the input side only stalls behind a waiting, unaccepted result
    `IPCF_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // reset empties the result register
    `IPCF_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind isolated_pixel_class_filter_core ipcf_checker u_checker (.*);
